### hw/rtl/cse_pkg.sv
// Package for the C-style string escaper: character constants,
// configuration register indexes and escape helper functions.
// No dependencies.
`default_nettype none

package cse_pkg;

    // width of one character, of the configuration index and of the configuration data
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // most output characters that one input item can cause
    localparam int MAX_RES   = 6;
    localparam int RES_IDX_W = 3;
    localparam int BODY_MAX  = 4;

    // codes below this are control characters
    localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ESC_DOUBLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_SINGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_STYLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_WHEN  = 2'd3;

    // character constants
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;

    // control character codes with a short letter escape
    localparam logic [CHAR_W-1:0] CC_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CC_BEL = 8'd7;
    localparam logic [CHAR_W-1:0] CC_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CC_HT  = 8'd9;
    localparam logic [CHAR_W-1:0] CC_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CC_VT  = 8'd11;
    localparam logic [CHAR_W-1:0] CC_FF  = 8'd12;
    localparam logic [CHAR_W-1:0] CC_CR  = 8'd13;

    // configuration register set
    typedef struct packed {
        logic       esc_double;
        logic       esc_single;
        logic [1:0] quote_style;
        logic       quote_when;
    } cse_cfg_t;

    // lower-case hex digit of a nibble
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 4'd10)
        begin
            r = CH_ZERO + {4'd0, v};
        end
        else
        begin
            r = CH_LOW_A + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

    // short letter escape of a control character, zero when it has none
    function automatic logic [CHAR_W-1:0] esc_letter(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        case (c)
            CC_NUL:  r = 8'h30;
            CC_BEL:  r = 8'h61;
            CC_BS:   r = 8'h62;
            CC_HT:   r = 8'h74;
            CC_LF:   r = 8'h6E;
            CC_VT:   r = 8'h76;
            CC_FF:   r = 8'h66;
            CC_CR:   r = 8'h72;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/c_string_escaper_unit.sv
// C-style string escaper, top level: input register, escape expansion
// and a result buffer that emits one character per cycle while out_stall is low.
// Depends on cse_pkg.
`default_nettype none

// An item is held in the input register and then loaded into the result buffer for output.
// Throughput: one result per cycle while out_stall is low; an item yields 1 to 6 results (one
// per output character: up to four for the escape plus an opening and a closing quote).
// The result buffer drains while the next item is already held in the input register.
// Reset clears all valid flags, the configuration registers and the escape flag.
module c_string_escaper_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration write port
    input  wire logic                       cfg_we,
    input  wire logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [cse_pkg::CHAR_W-1:0] in_char,
    input  wire logic                       first_char,
    input  wire logic                       last_char,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [cse_pkg::CHAR_W-1:0]      out_char,
    output logic                            run_last,
    output logic                            string_end,
    output logic                            quote_needed
);
    import cse_pkg::*;

    // configuration registers
    cse_cfg_t cfg_reg;

    // input register
    logic              in_vld_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              first_reg;
    logic              last_reg;

    // result buffer
    logic                 buf_vld_reg;
    logic [CHAR_W-1:0]    seq_reg [MAX_RES];
    logic [RES_IDX_W-1:0] idx_reg;
    logic [RES_IDX_W-1:0] lst_reg;
    logic                 end_reg;
    logic                 qn_reg;

    // string state
    logic saw_escape_reg;
    logic saw_escape_next;

    // expansion results
    logic [CHAR_W-1:0]    seq_next [MAX_RES];
    logic [RES_IDX_W-1:0] lst_next;
    logic                 qn_next;

    logic [CHAR_W-1:0]    body [BODY_MAX];
    logic [RES_IDX_W-1:0] blen;
    logic [RES_IDX_W-1:0] base;
    logic                 esc;
    logic [CHAR_W-1:0]    quote_ch;
    logic                 always_q;
    logic                 open_q;
    logic                 close_q;
    logic [CHAR_W-1:0]    letter;

    // handshake control
    logic in_take;
    logic out_take;
    logic buf_done;
    logic buf_free;
    logic load;

    assign out_take = buf_vld_reg && !out_stall;
    assign buf_done = out_take && (idx_reg == lst_reg);
    assign buf_free = !buf_vld_reg || buf_done;
    assign load     = in_vld_reg && buf_free;
    assign in_stall = in_vld_reg && !buf_free;
    assign in_take  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ESC_DOUBLE:  cfg_reg.esc_double  <= cfg_wdata[0];
                REG_ESC_SINGLE:  cfg_reg.esc_single  <= cfg_wdata[0];
                REG_QUOTE_STYLE: cfg_reg.quote_style <= cfg_wdata[1:0];
                REG_QUOTE_WHEN:  cfg_reg.quote_when  <= cfg_wdata[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (load)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg  <= in_char;
            first_reg <= first_char;
            last_reg  <= last_char;
        end
    end

    // escaped body of the character
    always_comb
    begin
        letter = esc_letter(char_reg);
        for (int k = 0; k < BODY_MAX; k++)
        begin
            body[k] = '0;
        end
        if (char_reg < CTRL_LIMIT)
        begin
            body[0] = CH_BSLASH;
            esc     = 1'b1;
            if (letter != '0)
            begin
                body[1] = letter;
                blen    = 3'd2;
            end
            else
            begin
                body[1] = CH_X;
                body[2] = hex_digit(char_reg[7:4]);
                body[3] = hex_digit(char_reg[3:0]);
                blen    = 3'd4;
            end
        end
        else if ((char_reg == CH_DQUOTE && cfg_reg.esc_double)
                 || (char_reg == CH_SQUOTE && cfg_reg.esc_single)
                 || char_reg == CH_BSLASH)
        begin
            body[0] = CH_BSLASH;
            body[1] = char_reg;
            blen    = 3'd2;
            esc     = 1'b1;
        end
        else
        begin
            body[0] = char_reg;
            blen    = 3'd1;
            esc     = 1'b0;
        end
    end

    // quote selection, double quotes win
    always_comb
    begin
        if (cfg_reg.quote_style[0])
        begin
            quote_ch = CH_DQUOTE;
        end
        else if (cfg_reg.quote_style[1])
        begin
            quote_ch = CH_SQUOTE;
        end
        else
        begin
            quote_ch = '0;
        end
        always_q = (cfg_reg.quote_style != 2'd0) && !cfg_reg.quote_when;
        open_q   = first_reg && always_q;
        close_q  = last_reg && always_q;
        base     = open_q ? 3'd1 : 3'd0;
    end

    // full output sequence with optional quotes
    always_comb
    begin
        for (int j = 0; j < MAX_RES; j++)
        begin
            seq_next[j] = '0;
        end
        if (open_q)
        begin
            seq_next[0] = quote_ch;
        end
        for (int k = 0; k < BODY_MAX; k++)
        begin
            if (RES_IDX_W'(k) < blen)
            begin
                seq_next[base + RES_IDX_W'(k)] = body[k];
            end
        end
        if (close_q)
        begin
            seq_next[base + blen] = quote_ch;
        end
        lst_next = base + blen - 3'd1 + {2'd0, close_q};
    end

    // escape flag of the running string
    always_comb
    begin
        saw_escape_next = (first_reg ? 1'b0 : saw_escape_reg) | esc;
        qn_next = last_reg && (cfg_reg.quote_style != 2'd0) && cfg_reg.quote_when
                  && saw_escape_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_escape_reg <= 1'b0;
        end
        else if (load)
        begin
            saw_escape_reg <= saw_escape_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else if (load)
        begin
            buf_vld_reg <= 1'b1;
            idx_reg     <= '0;
        end
        else if (buf_done)
        begin
            buf_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else if (out_take)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg <= seq_next;
            lst_reg <= lst_next;
            end_reg <= last_reg;
            qn_reg  <= qn_next;
        end
    end

    // output transaction fields
    always_comb
    begin
        out_valid    = buf_vld_reg;
        out_char     = seq_reg[idx_reg];
        run_last     = (idx_reg == lst_reg);
        string_end   = run_last && end_reg;
        quote_needed = run_last && qn_reg;
    end

endmodule

`default_nettype wire

### verif/c_string_escaper_unit_tb.sv
// Testbench for the C-style string escaper: directed and random character
// strings under several register settings, checked against a built-in predictor.
// Depends on cse_pkg and c_string_escaper_unit.
`default_nettype none

module c_string_escaper_unit_tb;

    import cse_pkg::*;

    // one input transaction
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              first;
        logic              last;
    } char_xact_t;

    // one output transaction
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              run_last;
        logic              string_end;
        logic              quote_needed;
    } esc_char_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     in_char;
    logic                  first_char;
    logic                  last_char;
    logic                  out_valid;
    logic                  out_stall;
    logic [CHAR_W-1:0]     out_char;
    logic                  run_last;
    logic                  string_end;
    logic                  quote_needed;

    // pending input characters and expected escaped characters
    char_xact_t char_q[$];
    esc_char_t  escaped_q[$];

    // predictor copy of the registers and the escape flag
    logic       m_esc_double;
    logic       m_esc_single;
    logic [1:0] m_quote_style;
    logic       m_quote_when;
    logic       saw_esc;

    string hex_digits = "0123456789abcdef";
    int    idle_pct;
    int    mismatch_cnt;
    bit    in_taken;

    c_string_escaper_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_char      (in_char),
        .first_char   (first_char),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .run_last     (run_last),
        .string_end   (string_end),
        .quote_needed (quote_needed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // expected escaped characters for one accepted input character
    task automatic predict_escape(input char_xact_t it);
        logic [CHAR_W-1:0] seq[$];
        logic [CHAR_W-1:0] qch;
        logic              wrap;
        esc_char_t         r;
        wrap = (m_quote_style != 2'd0) && !m_quote_when;
        qch  = m_quote_style[0] ? CH_DQUOTE : CH_SQUOTE;
        if (it.first)
        begin
            saw_esc = 1'b0;
            if (wrap)
                seq.push_back(qch);
        end
        if (it.ch < CTRL_LIMIT)
        begin
            seq.push_back(CH_BSLASH);
            case (it.ch)
                CC_NUL:  seq.push_back(CH_ZERO);
                CC_BEL:  seq.push_back("a");
                CC_BS:   seq.push_back("b");
                CC_HT:   seq.push_back("t");
                CC_LF:   seq.push_back("n");
                CC_VT:   seq.push_back("v");
                CC_FF:   seq.push_back("f");
                CC_CR:   seq.push_back("r");
                default:
                begin
                    seq.push_back(CH_X);
                    seq.push_back(hex_digits[it.ch[7:4]]);
                    seq.push_back(hex_digits[it.ch[3:0]]);
                end
            endcase
            saw_esc = 1'b1;
        end
        else
        begin
            if ((it.ch == CH_DQUOTE && m_esc_double) || (it.ch == CH_SQUOTE && m_esc_single)
                || it.ch == CH_BSLASH)
            begin
                seq.push_back(CH_BSLASH);
                saw_esc = 1'b1;
            end
            seq.push_back(it.ch);
        end
        if (it.last && wrap)
            seq.push_back(qch);
        foreach (seq[k])
        begin
            r.ch           = seq[k];
            r.run_last     = (k == seq.size() - 1);
            r.string_end   = r.run_last && it.last;
            r.quote_needed = r.string_end && (m_quote_style != 2'd0) && m_quote_when
                             && saw_esc;
            escaped_q.push_back(r);
        end
    endtask

    // monitor: check output transactions, then predict accepted inputs
    always @(posedge clk)
    begin
        esc_char_t e;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (escaped_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: char %02h rl %0b se %0b qn %0b",
                                 out_char, run_last, string_end, quote_needed);
                end
                else
                begin
                    e = escaped_q.pop_front();
                    if (out_char !== e.ch || run_last !== e.run_last
                        || string_end !== e.string_end || quote_needed !== e.quote_needed)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: exp char %02h rl %0b se %0b qn %0b, ",
                                      "got char %02h rl %0b se %0b qn %0b"},
                                     e.ch, e.run_last, e.string_end, e.quote_needed,
                                     out_char, run_last, string_end, quote_needed);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                predict_escape('{ch: in_char, first: first_char, last: last_char});
            end
        end
    end

    // driver: present queued characters and stall the output side at random
    always @(negedge clk)
    begin
        char_xact_t it;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < idle_pct);
            if (in_valid && !in_taken)
            begin
                // hold the stalled transaction
            end
            else if (char_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                it = char_q.pop_front();
                in_valid   <= 1'b1;
                in_char    <= it.ch;
                first_char <= it.first;
                last_char  <= it.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic f, input logic l);
        char_q.push_back('{ch: c, first: f, last: l});
    endtask

    // one register write per cycle; the caller lowers the write enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        case (idx)
            REG_ESC_DOUBLE:  m_esc_double  = d[0];
            REG_ESC_SINGLE:  m_esc_single  = d[0];
            REG_QUOTE_STYLE: m_quote_style = d;
            default:         m_quote_when  = d[0];
        endcase
    endtask

    task automatic set_escaper(input logic ed, input logic es, input logic [1:0] qs,
                               input logic qw);
        write_reg(REG_ESC_DOUBLE, {1'b0, ed});
        write_reg(REG_ESC_SINGLE, {1'b0, es});
        write_reg(REG_QUOTE_STYLE, qs);
        write_reg(REG_QUOTE_WHEN, {1'b0, qw});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every character is accepted and every result has arrived
    task automatic wait_drained();
        while (char_q.size() != 0 || in_valid || escaped_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // random character, weighted toward control codes, quotes and backslash
    function automatic logic [CHAR_W-1:0] pick_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return CHAR_W'($urandom_range(31));
        if (sel < 45)
        begin
            case ($urandom_range(2))
                0:       return CH_DQUOTE;
                1:       return CH_SQUOTE;
                default: return CH_BSLASH;
            endcase
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    // mostly well-formed strings, some characters with random marks
    task automatic queue_strings(input int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                push_char(pick_char(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                cnt++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    push_char(pick_char(), k == 0, k == len - 1);
                cnt += len;
            end
        end
    endtask

    task automatic run_phase(input logic ed, input logic es, input logic [1:0] qs,
                             input logic qw, input int n, input int idle);
        set_escaper(ed, es, qs, qw);
        idle_pct = idle;
        queue_strings(n);
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        in_char       = '0;
        first_char    = 1'b0;
        last_char     = 1'b0;
        out_stall     = 1'b0;
        m_esc_double  = 1'b0;
        m_esc_single  = 1'b0;
        m_quote_style = 2'd0;
        m_quote_when  = 1'b0;
        saw_esc       = 1'b0;
        idle_pct      = 31;
        mismatch_cnt  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every short escape, hex escapes, extremes and quote cases
        set_escaper(1'b1, 1'b1, 2'd1, 1'b0);
        push_char("A", 1'b1, 1'b1);
        push_char(CC_NUL, 1'b1, 1'b0);
        push_char(CC_BEL, 1'b0, 1'b0);
        push_char(CC_BS, 1'b0, 1'b0);
        push_char(CC_HT, 1'b0, 1'b0);
        push_char(CC_LF, 1'b0, 1'b0);
        push_char(CC_VT, 1'b0, 1'b0);
        push_char(CC_FF, 1'b0, 1'b0);
        push_char(CC_CR, 1'b0, 1'b0);
        push_char(8'd1, 1'b0, 1'b0);
        push_char(8'd26, 1'b0, 1'b0);
        push_char(8'd31, 1'b0, 1'b0);
        push_char(8'd32, 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char(CH_DQUOTE, 1'b0, 1'b0);
        push_char(CH_SQUOTE, 1'b0, 1'b0);
        push_char(8'd127, 1'b0, 1'b0);
        push_char(8'd128, 1'b0, 1'b0);
        push_char(8'd255, 1'b0, 1'b1);
        // new string starts while the previous one is still open
        push_char("H", 1'b1, 1'b0);
        push_char(CC_NUL, 1'b1, 1'b0);
        push_char("i", 1'b0, 1'b1);
        // characters with no first mark extend the current string
        push_char("2", 1'b0, 1'b0);
        push_char("3", 1'b0, 1'b1);
        wait_drained();

        // random strings under several settings; one phase runs without idling
        run_phase(1'b0, 1'b0, 2'd0, 1'b0, 27, 31);
        run_phase(1'b1, 1'b0, 2'd2, 1'b0, 27, 31);
        run_phase(1'b0, 1'b1, 2'd3, 1'b0, 27, 0);
        run_phase(1'b1, 1'b1, 2'd1, 1'b1, 27, 31);
        run_phase(1'b0, 1'b0, 2'd2, 1'b1, 27, 31);
        run_phase(1'b1, 1'b1, 2'd0, 1'b1, 27, 31);
        run_phase(1'b0, 1'b1, 2'd3, 1'b1, 27, 31);

        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && escaped_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
